>>> hdl/gdad_pkg.sv
`timescale 1ns / 1ps
package gdad_pkg;

   localparam logic [15:0] MinYearExcl   = 16'd1600;
   localparam logic [3:0]  MonthsPerYear = 4'd12;
   localparam logic [4:0]  LeapFebDays   = 5'd29;
   localparam logic [15:0] YearLimit     = 16'hFFFF;
   localparam logic [8:0]  Cycle400      = 9'd400;
   localparam logic [8:0]  LastRem400    = 9'd399;
   localparam logic [3:0]  MonthFeb      = 4'd2;
   localparam logic [3:0]  MonthJan      = 4'd1;
   localparam logic [4:0]  DaysDec       = 5'd31;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_CHECK,
      ST_WALK,
      ST_DONE
   } gdad_state_type;

   typedef struct packed {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
      logic [15:0] add;
   } gdad_req_type;

   typedef struct packed {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
      logic        date_valid;
      logic        year_overflow;
   } gdad_result_type;

   // The remainder of the year by 400 settles the leap rule: divisible by 4,
   // and not a multiple of 100 unless it is a multiple of 400.
   function automatic logic leap_from_rem(input logic [8:0] rem);
      leap_from_rem = (rem[1:0] == 2'd0) &&
                      (rem != 9'd100) && (rem != 9'd200) && (rem != 9'd300);
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = leap ? LeapFebDays : 5'd28;
         default:                                   len = 5'd0;
      endcase
      month_days = len;
   endfunction

endpackage

>>> hdl/gdad_core.sv
`timescale 1ns / 1ps
module gdad_core
   import gdad_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  gdad_req_type    req,
   output logic            ready,
   output logic            done,
   input  logic            take,
   output gdad_result_type result
);

   gdad_state_type  state_ff, state_in;
   logic [16:0]     acc_ff, acc_in;
   logic [8:0]      rem_ff, rem_in;
   logic [3:0]      month_ff, month_in;
   logic [15:0]     year_ff, year_in;
   logic [4:0]      day0_ff, day0_in;
   logic [15:0]     add_ff, add_in;
   gdad_result_type res_ff, res_in;

   logic [16:0]     sub_b;
   logic [17:0]     diff;
   logic            borrow;
   logic            greater;
   logic            leap;
   logic [4:0]      len;

   assign leap    = leap_from_rem(rem_ff);
   assign len     = month_days(month_ff, leap);
   assign sub_b   = (state_ff == ST_MOD) ? {8'd0, Cycle400} : {12'd0, len};
   assign diff    = {1'b0, acc_ff} - {1'b0, sub_b};
   assign borrow  = diff[17];
   assign greater = !borrow && (diff[16:0] != 17'd0);

   assign ready  = (state_ff == ST_IDLE);
   assign done   = (state_ff == ST_DONE);
   assign result = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      day0_ff  <= day0_in;
      add_ff   <= add_in;
      res_ff   <= res_in;
   end

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      month_in = month_ff;
      year_in  = year_ff;
      day0_in  = day0_ff;
      add_in   = add_ff;
      res_in   = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               acc_in   = {1'b0, req.year};
               year_in  = req.year;
               month_in = req.month;
               day0_in  = req.day;
               add_in   = req.add;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (!borrow) begin
               acc_in = diff[16:0];
            end else begin
               rem_in   = acc_ff[8:0];
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((year_ff > MinYearExcl) && (month_ff >= MonthJan) &&
                (month_ff <= MonthsPerYear) && (day0_ff != 5'd0) && (day0_ff <= len)) begin
               acc_in   = {12'd0, day0_ff} + {1'b0, add_ff};
               state_in = ST_WALK;
            end else begin
               res_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_WALK: begin
            if (greater) begin
               acc_in = diff[16:0];
               if (month_ff == MonthsPerYear) begin
                  month_in = MonthJan;
                  if (year_ff == YearLimit) begin
                     res_in.day           = DaysDec;
                     res_in.month         = MonthsPerYear;
                     res_in.year          = YearLimit;
                     res_in.date_valid    = 1'b1;
                     res_in.year_overflow = 1'b1;
                     state_in             = ST_DONE;
                  end else begin
                     year_in = year_ff + 16'd1;
                     rem_in  = (rem_ff == LastRem400) ? 9'd0 : rem_ff + 9'd1;
                  end
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end else begin
               res_in.day           = acc_ff[4:0];
               res_in.month         = month_ff;
               res_in.year          = year_ff;
               res_in.date_valid    = 1'b1;
               res_in.year_overflow = 1'b0;
               state_in             = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/gregorian_date_add_days_top.sv
`timescale 1ns / 1ps
// Adds a day count to a Gregorian date, one item at a time.
// The request channel carries the start date and the count; an item is taken
// when req_valid is high and req_stall is low. The block raises req_stall from
// the cycle after it takes an item until that item's result has been moved to
// the output register.
// The result channel carries the resulting date with date_valid and
// year_overflow; an item is delivered when rsp_valid is high and rsp_stall low.
// An invalid date gives all zero fields. A year past 65535 saturates to
// 31/12/65535 with year_overflow set.
// One shared subtractor first reduces the year by repeated subtraction of 400
// and then steps one month per cycle; an invalid date skips the month walk.
// A count of 65535 walks up to about 2155 months.
// While rsp_stall holds a result, the next item may still be taken and worked
// on; it waits in the core until the output register is free.
// Reset is synchronous and active high; it empties the output register and
// returns the sequencer to idle.
module gregorian_date_add_days_top
   import gdad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_start_day,
   input  logic [3:0]  req_start_month,
   input  logic [15:0] req_start_year,
   input  logic [15:0] req_days_to_add,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_result_day,
   output logic [3:0]  rsp_result_month,
   output logic [15:0] rsp_result_year,
   output logic        rsp_date_valid,
   output logic        rsp_year_overflow
);

   gdad_req_type    req;
   gdad_result_type core_result;
   gdad_result_type out_ff, out_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            core_ready;
   logic            core_done;
   logic            take;

   assign req.day   = req_start_day;
   assign req.month = req_start_month;
   assign req.year  = req_start_year;
   assign req.add   = req_days_to_add;

   assign req_stall = !core_ready;
   assign take      = core_done && (!rsp_valid_ff || !rsp_stall);

   gdad_core u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (req_valid && core_ready),
      .req    (req),
      .ready  (core_ready),
      .done   (core_done),
      .take   (take),
      .result (core_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_in       = out_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         out_in       = core_result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_day    = out_ff.day;
   assign rsp_result_month  = out_ff.month;
   assign rsp_result_year   = out_ff.year;
   assign rsp_date_valid    = out_ff.date_valid;
   assign rsp_year_overflow = out_ff.year_overflow;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
   import gdad_pkg::*;

   localparam int unsigned CycleLimit     = 4_000_000;
   localparam int unsigned LongHoldCycles = 3000;
   localparam int unsigned DrainCycles    = 2500;
   localparam int unsigned RandomItems    = 250;
   localparam int unsigned MaxReported    = 10;

   typedef struct packed {
      gdad_req_type    req;
      logic            typed;
      gdad_result_type res;
   } date_case_type;

   localparam gdad_result_type NoDate    = '0;
   localparam gdad_result_type Saturated = '{DaysDec, MonthsPerYear, YearLimit, 1'b1, 1'b1};
   localparam int unsigned     NumCases  = 23;

   // A typed result is used for invalid dates, zero counts and saturation;
   // the other rows are checked against the predictor.
   localparam date_case_type DateCases [0:NumCases-1] = '{
      '{'{5'd1,  4'd1,  16'd1601,  16'd0},     1'b1, '{5'd1, 4'd1, 16'd1601, 1'b1, 1'b0}},
      '{'{5'd1,  4'd1,  16'd1600,  16'd5},     1'b1, NoDate},
      '{'{5'd1,  4'd1,  16'd0,     16'd0},     1'b1, NoDate},
      '{'{5'd10, 4'd0,  16'd2000,  16'd1},     1'b1, NoDate},
      '{'{5'd10, 4'd13, 16'd2000,  16'd1},     1'b1, NoDate},
      '{'{5'd1,  4'd15, 16'd2000,  16'd0},     1'b1, NoDate},
      '{'{5'd0,  4'd5,  16'd2000,  16'd3},     1'b1, NoDate},
      '{'{5'd31, 4'd4,  16'd2021,  16'd0},     1'b1, NoDate},
      '{'{5'd29, 4'd2,  16'd2001,  16'd0},     1'b1, NoDate},
      '{'{5'd29, 4'd2,  16'd1900,  16'd0},     1'b1, NoDate},
      '{'{5'd29, 4'd2,  16'd2000,  16'd0},     1'b1, '{5'd29, 4'd2, 16'd2000, 1'b1, 1'b0}},
      '{'{5'd29, 4'd2,  16'd2024,  16'd1},     1'b0, NoDate},
      '{'{5'd28, 4'd2,  16'd2023,  16'd1},     1'b0, NoDate},
      '{'{5'd31, 4'd12, 16'd1999,  16'd1},     1'b0, NoDate},
      '{'{5'd31, 4'd12, 16'd65535, 16'd0},     1'b1, '{5'd31, 4'd12, 16'd65535, 1'b1, 1'b0}},
      '{'{5'd31, 4'd12, 16'd65535, 16'd1},     1'b1, Saturated},
      '{'{5'd1,  4'd1,  16'd65535, 16'd65535}, 1'b1, Saturated},
      '{'{5'd31, 4'd15, 16'd65535, 16'd65535}, 1'b1, NoDate},
      '{'{5'd1,  4'd1,  16'd1601,  16'd65535}, 1'b0, NoDate},
      '{'{5'd31, 4'd1,  16'd2024,  16'd29},    1'b0, NoDate},
      '{'{5'd15, 4'd6,  16'd40000, 16'd1000},  1'b0, NoDate},
      '{'{5'd31, 4'd1,  16'd1601,  16'd0},     1'b1, '{5'd31, 4'd1, 16'd1601, 1'b1, 1'b0}},
      '{'{5'd30, 4'd11, 16'd65535, 16'd31},    1'b0, NoDate}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [4:0]  req_start_day;
   logic [3:0]  req_start_month;
   logic [15:0] req_start_year;
   logic [15:0] req_days_to_add;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [4:0]  rsp_result_day;
   logic [3:0]  rsp_result_month;
   logic [15:0] rsp_result_year;
   logic        rsp_date_valid;
   logic        rsp_year_overflow;

   gdad_result_type dates_pending [$];
   logic            cur_typed;
   gdad_result_type cur_typed_result;
   int unsigned     results_seen;
   int unsigned     mismatches;
   int unsigned     cycle_count;

   gregorian_date_add_days_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_day     (req_start_day),
      .req_start_month   (req_start_month),
      .req_start_year    (req_start_year),
      .req_days_to_add   (req_days_to_add),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_day    (rsp_result_day),
      .rsp_result_month  (rsp_result_month),
      .rsp_result_year   (rsp_result_year),
      .rsp_date_valid    (rsp_date_valid),
      .rsp_year_overflow (rsp_year_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic is_leap_year(input int unsigned year);
      return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
   endfunction

   function automatic int unsigned month_length(input int unsigned month,
                                                input int unsigned year);
      case (month)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         MonthFeb:              return is_leap_year(year) ? LeapFebDays : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic gdad_result_type add_days_to_date(input gdad_req_type r);
      gdad_result_type res;
      int unsigned     day;
      int unsigned     month;
      int unsigned     year;
      res   = '0;
      day   = 32'(r.day);
      month = 32'(r.month);
      year  = 32'(r.year);
      if (!(year > MinYearExcl && month >= 1 && month <= MonthsPerYear &&
            day >= 1 && day <= month_length(month, year)))
         return res;
      day = day + 32'(r.add);
      while (day > month_length(month, year)) begin
         day   = day - month_length(month, year);
         month = month + 1;
         if (month > MonthsPerYear) begin
            month = 32'(MonthJan);
            year  = year + 1;
            if (year > YearLimit)
               break;
         end
      end
      res.date_valid = 1'b1;
      if (year > YearLimit) begin
         res.day           = DaysDec;
         res.month         = MonthsPerYear;
         res.year          = YearLimit;
         res.year_overflow = 1'b1;
      end else begin
         res.day   = day[4:0];
         res.month = month[3:0];
         res.year  = year[15:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      gdad_result_type got;
      gdad_result_type want;
      gdad_req_type    taken;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_result_day, rsp_result_month, rsp_result_year,
                    rsp_date_valid, rsp_year_overflow};
            results_seen = results_seen + 1;
            if (dates_pending.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= MaxReported)
                  $display("unexpected item: %0d/%0d/%0d valid %b overflow %b",
                           got.day, got.month, got.year, got.date_valid,
                           got.year_overflow);
            end else begin
               want = dates_pending.pop_front();
               if (got.day !== want.day || got.month !== want.month ||
                   got.year !== want.year || got.date_valid !== want.date_valid ||
                   got.year_overflow !== want.year_overflow) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= MaxReported)
                     $display("item %0d: expected %0d/%0d/%0d v%b o%b, got %0d/%0d/%0d v%b o%b",
                              results_seen, want.day, want.month, want.year,
                              want.date_valid, want.year_overflow, got.day, got.month,
                              got.year, got.date_valid, got.year_overflow);
               end
            end
         end
         if (req_valid && !req_stall) begin
            taken = '{req_start_day, req_start_month, req_start_year, req_days_to_add};
            dates_pending.push_back(cur_typed ? cur_typed_result : add_days_to_date(taken));
         end
      end
   end

   initial begin
      int unsigned run_len;
      int unsigned pick;
      logic        stall_val;
      bit          long_hold_done;
      rsp_stall      = 1'b0;
      long_hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         if (!long_hold_done && results_seen >= 40) begin
            long_hold_done = 1'b1;
            stall_val      = 1'b1;
            run_len        = LongHoldCycles;
         end else if (pick < 10) begin
            stall_val = 1'b0;
            run_len   = $urandom_range(50, 150);
         end else if (pick < 15) begin
            stall_val = 1'b1;
            run_len   = $urandom_range(20, 80);
         end else begin
            stall_val = ($urandom_range(0, 2) == 0);
            run_len   = $urandom_range(1, 4);
         end
         repeat (run_len) begin
            @(negedge clock);
            rsp_stall <= stall_val;
         end
      end
   end

   task automatic offer_date(input gdad_req_type r, input int unsigned gap,
                             input logic typed, input gdad_result_type res);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_start_day    <= r.day;
      req_start_month  <= r.month;
      req_start_year   <= r.year;
      req_days_to_add  <= r.add;
      req_valid        <= 1'b1;
      cur_typed        = typed;
      cur_typed_result = res;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_dates;
      req_valid <= 1'b0;
      @(negedge clock);
      while (dates_pending.size() != 0) @(negedge clock);
   endtask

   function automatic int unsigned random_gap(input int unsigned idx);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (idx >= 100 && idx < 130)
         return 0;
      if (pick < 60)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   initial begin
      gdad_req_type r;
      int unsigned  pick;
      int unsigned  len;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_start_day    = '0;
      req_start_month  = '0;
      req_start_year   = '0;
      req_days_to_add  = '0;
      cur_typed        = 1'b0;
      cur_typed_result = '0;
      results_seen     = 0;
      mismatches       = 0;
      cycle_count      = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (3) @(negedge clock);

      for (int i = 0; i < NumCases; i++)
         offer_date(DateCases[i].req, random_gap(0), DateCases[i].typed, DateCases[i].res);
      drain_dates();

      for (int unsigned i = 0; i < RandomItems; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            r.day   = 5'($urandom);
            r.month = 4'($urandom);
            r.year  = 16'($urandom);
            r.add   = 16'($urandom);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
               r.year = 16'($urandom_range(65300, 65535));
            else if (pick < 30)
               r.year = 16'($urandom_range(1601, 2500));
            else
               r.year = 16'($urandom_range(1601, 65535));
            r.month = 4'($urandom_range(1, 12));
            len     = month_length(32'(r.month), 32'(r.year));
            r.day   = 5'(($urandom_range(0, 19) == 0) ? len + 1 : $urandom_range(1, len));
            pick    = $urandom_range(0, 99);
            if (pick < 10)
               r.add = '0;
            else if (pick < 65)
               r.add = 16'($urandom_range(1, 400));
            else if (pick < 85)
               r.add = 16'($urandom_range(0, 4000));
            else
               r.add = 16'($urandom_range(0, 65535));
         end
         offer_date(r, random_gap(i), 1'b0, NoDate);
         if (i == 150)
            drain_dates();
      end

      drain_dates();
      repeat (DrainCycles) @(negedge clock);
      if (mismatches == 0 && dates_pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> gregorian_date_add_days_top.f
hdl/gdad_pkg.sv
hdl/gdad_core.sv
hdl/gregorian_date_add_days_top.sv
sim/tb.sv
